// ===== rtl/ers_pkg.sv =====
// Shared types and codes for the elevator request scheduler.
package ers_pkg;

    // Width used for floor compares; holds every floor index up to 127.
    localparam int FLOOR_CMP_W = 7;

    localparam logic [1:0] MODE_CAR  = 2'd0;
    localparam logic [1:0] MODE_HALL = 2'd1;
    localparam logic [1:0] MODE_EVAL = 2'd2;
    localparam logic [1:0] MODE_STOP = 2'd3;

    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic REG_LOWEST  = 1'b0;
    localparam logic REG_HIGHEST = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] target_floor;
        logic       call_up;
        logic [2:0] current_floor;
    } ers_in_t;

    typedef struct packed {
        logic       accepted;
        logic [1:0] direction;
        logic       pending;
    } ers_out_t;

    // Broadcast from the top level to every floor cell.
    typedef struct packed {
        logic       set_car;
        logic       set_up;
        logic       set_down;
        logic [2:0] target;
        logic [2:0] current;
        logic [2:0] lowest;
        logic [2:0] highest;
    } ers_ctrl_t;

    // Rippled from cell to cell, low floor to high floor.
    typedef struct packed {
        logic ahead_up;
        logic ahead_down;
        logic any_next;
    } ers_chain_t;

endpackage

// ===== rtl/ers_floor_cell.sv =====
// One floor of the request row: holds the three request bits of that floor.
module ers_floor_cell import ers_pkg::*; #(
    parameter int INDEX = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ers_ctrl_t  ctrl,
    input  ers_chain_t chain_in,
    output ers_chain_t chain_out
);

    localparam logic [FLOOR_CMP_W-1:0] IDX = FLOOR_CMP_W'(INDEX);

    logic car_reg, car_next;
    logic up_reg, up_next;
    logic dn_reg, dn_next;
    logic hit;
    logic req_now;
    logic [FLOOR_CMP_W-1:0] cur_w, lo_w, hi_w, tgt_w;

    always_comb begin
        cur_w = FLOOR_CMP_W'(ctrl.current);
        lo_w  = FLOOR_CMP_W'(ctrl.lowest);
        hi_w  = FLOOR_CMP_W'(ctrl.highest);
        tgt_w = FLOOR_CMP_W'(ctrl.target);
        hit   = (tgt_w == IDX);

        car_next = car_reg | (ctrl.set_car  & hit);
        up_next  = up_reg  | (ctrl.set_up   & hit);
        dn_next  = dn_reg  | (ctrl.set_down & hit);

        req_now = car_reg | up_reg | dn_reg;

        // Windows above and below the car, clipped to the served range.
        chain_out.ahead_up   = chain_in.ahead_up
                             | (req_now & (IDX > cur_w) & (IDX <= hi_w));
        chain_out.ahead_down = chain_in.ahead_down
                             | (req_now & (IDX >= lo_w) & (IDX < cur_w));
        chain_out.any_next   = chain_in.any_next | car_next | up_next | dn_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            car_reg <= 1'b0;
            up_reg  <= 1'b0;
            dn_reg  <= 1'b0;
        end else begin
            car_reg <= car_next;
            up_reg  <= up_next;
            dn_reg  <= dn_next;
        end
    end

endmodule

// ===== rtl/elevator_request_scheduler_unit.sv =====
// Elevator request scheduler (SCAN) built on a row of floor cells.
//
// Input channel s_valid/s_ready/s_data carries one item per beat: a car
// request, a hall call, a direction re-evaluate or a stop-only write, each
// with the car's current floor. Every item gives exactly one result beat on
// m_valid/m_ready/m_data: whether the request was taken, the travel
// direction after the item and whether any request is pending.
// Throughput is one item per cycle while s_ready is high; the floor-cell row
// and the direction register update in the same cycle the item is taken, so
// the next item may follow at once.
// Results go through an output register backed by a one-entry skid stage;
// s_ready drops only while both hold a result, so a stalled receiver costs
// at most two buffered results before the input is held off.
// Reset (aresetn low, synchronous) clears all requests, sets the car idle,
// restores lowest_floor to 0 and highest_floor to 7 and empties the output.
// Configuration goes through the APB port: lowest_floor at 0x0,
// highest_floor at 0x4; write it only while no item is in flight.
module elevator_request_scheduler_unit import ers_pkg::*; #(
    parameter int FLOORS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ers_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output ers_out_t    m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [FLOOR_CMP_W-1:0] FLOORS_W = FLOOR_CMP_W'(FLOORS);

    logic [2:0] lowest_reg, highest_reg;
    logic [1:0] dir_reg, dir_next;

    logic       out_valid_reg, skid_valid_reg;
    ers_out_t   out_data_reg, skid_data_reg;

    ers_ctrl_t  ctrl;
    ers_chain_t chain [FLOORS+1];
    ers_out_t   result;

    logic       push, pop;
    logic       idle;
    logic       in_range, car_ok, hall_ok;
    logic       take;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_HIGHEST) ? {29'd0, highest_reg} : {29'd0, lowest_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lowest_reg  <= 3'd0;
            highest_reg <= 3'd7;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_HIGHEST) begin
                highest_reg <= pwdata[2:0];
            end else begin
                lowest_reg <= pwdata[2:0];
            end
        end
    end

    assign s_ready = !skid_valid_reg;
    assign push    = s_valid & s_ready;
    assign pop     = out_valid_reg & m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        idle     = (dir_reg == DIR_IDLE);
        in_range = (s_data.target_floor >= lowest_reg)
                 & (s_data.target_floor <= highest_reg)
                 & (FLOOR_CMP_W'(s_data.target_floor) < FLOORS_W);
        car_ok   = in_range & !((s_data.target_floor == s_data.current_floor) & idle);
        hall_ok  = car_ok
                 & !((s_data.target_floor == highest_reg) & s_data.call_up)
                 & !((s_data.target_floor == lowest_reg) & !s_data.call_up);

        take = 1'b0;
        case (s_data.mode)
            MODE_CAR:  take = car_ok;
            MODE_HALL: take = hall_ok;
            MODE_STOP: take = in_range;
            default:   take = 1'b0;
        endcase

        ctrl.set_car  = push & take
                      & ((s_data.mode == MODE_CAR) | (s_data.mode == MODE_STOP));
        ctrl.set_up   = push & take & (s_data.mode == MODE_HALL) & s_data.call_up;
        ctrl.set_down = push & take & (s_data.mode == MODE_HALL) & !s_data.call_up;
        ctrl.target   = s_data.target_floor;
        ctrl.current  = s_data.current_floor;
        ctrl.lowest   = lowest_reg;
        ctrl.highest  = highest_reg;
    end

    assign chain[0] = '0;

    for (genvar i = 0; i < FLOORS; i++) begin : g_cell
        ers_floor_cell #(
            .INDEX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    always_comb begin
        dir_next = dir_reg;
        case (s_data.mode)
            MODE_CAR, MODE_HALL: begin
                // Start an idle car toward the new request.
                if (take && idle) begin
                    if (s_data.current_floor < s_data.target_floor) begin
                        dir_next = DIR_UP;
                    end else if (s_data.current_floor > s_data.target_floor) begin
                        dir_next = DIR_DOWN;
                    end
                end
            end
            MODE_EVAL: begin
                if (!chain[FLOORS].any_next) begin
                    dir_next = DIR_IDLE;
                end else begin
                    case (dir_reg)
                        DIR_UP: begin
                            if (!chain[FLOORS].ahead_up) dir_next = DIR_DOWN;
                        end
                        DIR_DOWN: begin
                            if (!chain[FLOORS].ahead_down) dir_next = DIR_UP;
                        end
                        default: begin
                            if (chain[FLOORS].ahead_up) begin
                                dir_next = DIR_UP;
                            end else if (chain[FLOORS].ahead_down) begin
                                dir_next = DIR_DOWN;
                            end
                        end
                    endcase
                end
            end
            default: dir_next = dir_reg;
        endcase
        result.accepted  = take;
        result.direction = dir_next;
        result.pending   = chain[FLOORS].any_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg <= DIR_IDLE;
        end else if (push) begin
            dir_reg <= dir_next;
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
                if (push) skid_data_reg <= result;
            end else if (push) begin
                out_data_reg <= result;
            end
        end else if (push) begin
            skid_data_reg <= result;
        end
    end

endmodule

// ===== rtl/ers_checker.sv =====
// Port-level checks for the elevator request scheduler, bound to the top level.
module ers_checker import ers_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input ers_out_t m_data
);

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input held off with empty output");

    a_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.accepted |-> m_data.pending)
        else $error("taken request left nothing pending");

    a_move_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.direction != DIR_IDLE) |-> m_data.pending)
        else $error("car moving with no request pending");

endmodule

bind elevator_request_scheduler_unit ers_checker u_ers_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== verif/tb_elevator_request_scheduler_unit.sv =====
// Self-checking testbench for the elevator request scheduler: scripted and random beats.
`timescale 1ns / 100ps

module tb_elevator_request_scheduler_unit;
    import ers_pkg::*;

    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          NUM_PHASES      = 10;
    localparam int          ITEMS_PER_PHASE = 68;
    localparam logic [2:0]  ADDR_LOWEST     = {REG_LOWEST, 2'b00};
    localparam logic [2:0]  ADDR_HIGHEST    = {REG_HIGHEST, 2'b00};

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e  kind;
        ers_in_t    beat;
        bit         typed;
        ers_out_t   result;
        logic [2:0] lo;
        logic [2:0] hi;
    } script_row_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    ers_in_t     s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    ers_out_t    m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Scheduler state as predicted by the testbench
    logic [7:0] stop_mask  = '0;
    logic [7:0] up_calls   = '0;
    logic [7:0] down_calls = '0;
    logic [1:0] travel     = DIR_IDLE;
    logic [2:0] floor_lo   = 3'd0;
    logic [2:0] floor_hi   = 3'd7;

    ers_out_t    due_results [$];
    script_row_t script [$];
    int          errors       = 0;
    int          beats_sent   = 0;
    int          results_seen = 0;
    int          range_sets   = 0;
    int          cycle_count  = 0;
    bit          quiet        = 1'b0;
    int          phase_lo [NUM_PHASES] = '{3, 5, 0, 7, 2, 1, 0, 7, 0, 0};
    int          phase_hi [NUM_PHASES] = '{3, 2, 0, 7, 5, 6, 7, 0, 0, 0};

    elevator_request_scheduler_unit #(.FLOORS(8)) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic bit in_span(logic [2:0] f);
        return f >= floor_lo && f <= floor_hi;
    endfunction

    // Floors lo..hi inclusive; empty when lo > hi
    function automatic logic [7:0] window(int lo, int hi);
        logic [7:0] w;
        for (int i = 0; i < 8; i++) w[i] = (i >= lo) && (i <= hi);
        return w;
    endfunction

    function automatic void head_for(logic [2:0] cur, logic [2:0] tgt);
        if (travel == DIR_IDLE) begin
            if (cur < tgt) travel = DIR_UP;
            else if (cur > tgt) travel = DIR_DOWN;
        end
    endfunction

    function automatic ers_out_t schedule_step(ers_in_t b);
        logic [7:0] reqs;
        bit         go_up;
        bit         go_down;
        bit         take;
        ers_out_t   r;
        take = 1'b0;
        case (b.mode)
            MODE_CAR: begin
                if (in_span(b.target_floor)
                    && !(b.target_floor == b.current_floor && travel == DIR_IDLE)) begin
                    stop_mask[b.target_floor] = 1'b1;
                    head_for(b.current_floor, b.target_floor);
                    take = 1'b1;
                end
            end
            MODE_HALL: begin
                if (in_span(b.target_floor)
                    && !(b.target_floor == b.current_floor && travel == DIR_IDLE)
                    && !(b.target_floor == floor_hi && b.call_up)
                    && !(b.target_floor == floor_lo && !b.call_up)) begin
                    if (b.call_up) up_calls[b.target_floor] = 1'b1;
                    else down_calls[b.target_floor] = 1'b1;
                    head_for(b.current_floor, b.target_floor);
                    take = 1'b1;
                end
            end
            MODE_EVAL: begin
                reqs    = stop_mask | up_calls | down_calls;
                go_up   = |(reqs & window(int'(b.current_floor) + 1, int'(floor_hi)));
                go_down = |(reqs & window(int'(floor_lo), int'(b.current_floor) - 1));
                if (reqs == '0) travel = DIR_IDLE;
                else if (travel == DIR_UP) begin
                    if (!go_up) travel = DIR_DOWN;
                end else if (travel == DIR_DOWN) begin
                    if (!go_down) travel = DIR_UP;
                end else if (go_up) travel = DIR_UP;
                else if (go_down) travel = DIR_DOWN;
            end
            default: begin
                if (in_span(b.target_floor)) begin
                    stop_mask[b.target_floor] = 1'b1;
                    take = 1'b1;
                end
            end
        endcase
        r.accepted  = take;
        r.direction = travel;
        r.pending   = |(stop_mask | up_calls | down_calls);
        return r;
    endfunction

    function automatic void add_row(logic [1:0] mode, logic [2:0] tgt, logic up,
                                    logic [2:0] cur);
        script_row_t r;
        r.kind   = ROW_ITEM;
        r.beat   = '{mode, tgt, up, cur};
        r.typed  = 1'b0;
        r.result = '0;
        r.lo     = '0;
        r.hi     = '0;
        script.push_back(r);
    endfunction

    function automatic void add_typed(logic [1:0] mode, logic [2:0] tgt, logic up,
                                      logic [2:0] cur, logic acc, logic [1:0] dir,
                                      logic pend);
        add_row(mode, tgt, up, cur);
        script[script.size() - 1].typed  = 1'b1;
        script[script.size() - 1].result = '{acc, dir, pend};
    endfunction

    function automatic void add_cfg(logic [2:0] lo, logic [2:0] hi);
        add_row(MODE_EVAL, '0, 1'b0, '0);
        script[script.size() - 1].kind = ROW_CFG;
        script[script.size() - 1].lo   = lo;
        script[script.size() - 1].hi   = hi;
    endfunction

    function automatic void build_script();
        // Fresh state: refusals and the first stop are known outright
        add_typed(MODE_EVAL, 3'd0, 1'b0, 3'd0, 1'b0, DIR_IDLE, 1'b0);
        add_typed(MODE_CAR,  3'd3, 1'b0, 3'd3, 1'b0, DIR_IDLE, 1'b0);
        add_typed(MODE_HALL, 3'd7, 1'b1, 3'd0, 1'b0, DIR_IDLE, 1'b0);
        add_typed(MODE_HALL, 3'd0, 1'b0, 3'd5, 1'b0, DIR_IDLE, 1'b0);
        add_typed(MODE_HALL, 3'd4, 1'b1, 3'd4, 1'b0, DIR_IDLE, 1'b0);
        add_typed(MODE_STOP, 3'd7, 1'b0, 3'd7, 1'b1, DIR_IDLE, 1'b1);
        add_typed(MODE_EVAL, 3'd0, 1'b1, 3'd7, 1'b0, DIR_IDLE, 1'b1);
        add_typed(MODE_CAR,  3'd2, 1'b0, 3'd5, 1'b1, DIR_DOWN, 1'b1);
        add_row(MODE_EVAL, 3'd0, 1'b0, 3'd3);
        add_row(MODE_EVAL, 3'd7, 1'b1, 3'd0);
        add_row(MODE_HALL, 3'd0, 1'b1, 3'd7);
        add_row(MODE_HALL, 3'd7, 1'b0, 3'd2);
        add_row(MODE_EVAL, 3'd0, 1'b0, 3'd7);
        add_row(MODE_CAR,  3'd7, 1'b0, 3'd7);
        // Narrow range: out-of-range floors and the new ends
        add_cfg(3'd2, 3'd5);
        add_row(MODE_CAR,  3'd1, 1'b0, 3'd3);
        add_row(MODE_HALL, 3'd6, 1'b0, 3'd3);
        add_row(MODE_HALL, 3'd5, 1'b1, 3'd3);
        add_row(MODE_HALL, 3'd2, 1'b0, 3'd3);
        add_row(MODE_EVAL, 3'd0, 1'b0, 3'd6);
        // Inverted range refuses everything
        add_cfg(3'd5, 3'd2);
        add_row(MODE_STOP, 3'd3, 1'b1, 3'd3);
        add_row(MODE_EVAL, 3'd3, 1'b1, 3'd3);
        add_cfg(3'd0, 3'd7);
    endfunction

    function automatic ers_in_t random_beat();
        ers_in_t b;
        int      r;
        r = $urandom_range(0, 9);
        if (r < 3) b.mode = MODE_CAR;
        else if (r < 6) b.mode = MODE_HALL;
        else if (r < 9) b.mode = MODE_EVAL;
        else b.mode = MODE_STOP;
        b.target_floor  = 3'($urandom_range(0, 7));
        b.call_up       = 1'($urandom_range(0, 1));
        b.current_floor = 3'($urandom_range(0, 7));
        return b;
    endfunction

    task automatic send_beat(ers_in_t b, bit typed, ers_out_t typed_result);
        int       gap;
        ers_out_t want;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = schedule_step(b);
        if (typed) want = typed_result;
        due_results.push_back(want);
        beats_sent++;
    endtask

    // Drop valid, let every result come back, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [2:0] val);
        logic [31:0] junk;
        junk    = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {junk[31:3], val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == ADDR_LOWEST) floor_lo = val;
        else floor_hi = val;
        // Read back through a second transfer
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== {29'd0, val}) begin
            $display("%0t: readback at 0x%0h expected %0d, got %0d", $time, addr, val, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_range(logic [2:0] lo, logic [2:0] hi);
        write_reg(ADDR_LOWEST, lo);
        write_reg(ADDR_HIGHEST, hi);
        range_sets++;
    endtask

    task automatic field_check(string name, logic [1:0] want, logic [1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result side: check each beat, stall at random
    initial begin
        int       stall_left;
        ers_out_t want;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got %b", $time, m_data);
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    field_check("accepted", 2'(want.accepted), 2'(m_data.accepted));
                    field_check("direction", want.direction, m_data.direction);
                    field_check("pending", 2'(want.pending), 2'(m_data.pending));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("elevator_request_scheduler_unit test failed");
        $finish;
    end

    initial begin
        logic [2:0] lo;
        logic [2:0] hi;
        build_script();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG) begin
                drain();
                set_range(script[i].lo, script[i].hi);
            end else begin
                send_beat(script[i].beat, script[i].typed, script[i].result);
            end
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 8) begin
                lo = 3'(phase_lo[p]);
                hi = 3'(phase_hi[p]);
            end else begin
                lo = 3'($urandom_range(0, 7));
                hi = 3'($urandom_range(0, 7));
            end
            quiet = (p % 4 == 3);
            set_range(lo, hi);
            repeat (ITEMS_PER_PHASE) send_beat(random_beat(), 1'b0, '0);
            drain();
        end
        quiet = 1'b0;
        repeat (8) @(posedge aclk);

        $display("Ran %0d request beats under %0d floor range settings, %0d results checked.",
                 beats_sent, range_sets, results_seen);
        $display("Mismatches found: %0d", errors);
        if (errors == 0) begin
            $display("elevator_request_scheduler_unit test passed");
        end else begin
            $display("elevator_request_scheduler_unit test failed");
        end
        $finish;
    end

endmodule
